/* design/assert_macros.svh */
// assertion helpers for the rational arithmetic unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every rising clock edge outside reset
`define RAU_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RAU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rau_pkg.sv */
`default_nettype none
package rau_pkg;
  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;
endpackage
`default_nettype wire

/* design/rational_arithmetic_unit.sv */
// channel | valid   | stall   | payload
// input   | valid_i | stall_o | action_i a_neg_i a_num_i a_den_i b_neg_i b_num_i b_den_i
// output  | valid_o | stall_i | r_neg_o r_num_o r_den_o status_o
//
// one item at a time; stall_o is high from the input transfer until the result leaves
// a zero denominator or zero divisor goes straight to the output; otherwise
// two shift-add products (multiply, divide) or three (add, subtract), a combine step,
// then the gcd (up to about 3*MAG_BITS remainder passes, each a restoring divide
// on one shared subtractor), two divides by the gcd and a final step
// reset clears the sequencer and the output valid; payload registers are not reset
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int MAG_BITS = 31
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     stall_o,
  input  wire logic [1:0]          action_i,
  input  wire logic                a_neg_i,
  input  wire logic [30:0]         a_num_i,
  input  wire logic [30:0]         a_den_i,
  input  wire logic                b_neg_i,
  input  wire logic [30:0]         b_num_i,
  input  wire logic [30:0]         b_den_i,
  output logic                     valid_o,
  input  wire logic                stall_i,
  output logic                     r_neg_o,
  output logic [30:0]              r_num_o,
  output logic [30:0]              r_den_o,
  output logic [1:0]               status_o
);
  localparam int WW = 2 * MAG_BITS + 1;  // wide word, holds a cross-product sum
  localparam int CW = $clog2(WW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADDSUB, S_GCD_CHK, S_DIVIDE, S_RED_N, S_RED_D, S_FINAL, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    MP_T1, MP_T2, MP_DEN
  } mphase_e;

  typedef enum logic [1:0] {
    DV_GCD, DV_N, DV_D
  } dmode_e;

  state_e  state_q;
  mphase_e mph_q;
  dmode_e  dm_q;
  logic [CW-1:0] cnt_q;

  logic [1:0]          act_q;
  logic                sa_q, sb_q, neg_q;
  logic [MAG_BITS-1:0] ad_q, bn_q, bd_q;
  logic [MAG_BITS-1:0] mc_q;          // multiplier shifted out lsb first
  logic [WW-1:0]       md_q;          // multiplicand shifted left
  logic [WW-1:0]       acc_q;         // product accumulator
  logic [WW-1:0]       t1_q, t2_q;
  logic [WW-1:0]       n_q, d_q;      // exact result before reduction
  logic [WW-1:0]       x_q, y_q;      // gcd operands
  logic [WW-1:0]       quo_q, rem_q, dvs_q;  // divider

  // the subtractor shared by the gcd and reduction divides
  logic [WW:0]   sub_w;
  logic [WW-1:0] rsh_w;
  assign rsh_w = {rem_q[WW-2:0], quo_q[WW-1]};
  assign sub_w = {1'b0, rsh_w} - {1'b0, dvs_q};

  logic [MAG_BITS-1:0] an_w, ad_w, bn_w, bd_w;
  assign an_w = a_num_i[MAG_BITS-1:0];
  assign ad_w = a_den_i[MAG_BITS-1:0];
  assign bn_w = b_num_i[MAG_BITS-1:0];
  assign bd_w = b_den_i[MAG_BITS-1:0];

  logic eb_w;
  assign eb_w = (act_q == ACT_SUB) ? ~sb_q : sb_q;

  assign stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
      mph_q   <= MP_T1;
      dm_q    <= DV_GCD;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            act_q <= action_i;
            sa_q  <= a_neg_i;
            sb_q  <= b_neg_i;
            ad_q <= ad_w; bn_q <= bn_w; bd_q <= bd_w;
            if (ad_w == '0 || bd_w == '0) begin
              status_o <= ST_ZERO_DEN;
              r_neg_o <= 1'b0; r_num_o <= '0; r_den_o <= '0;
              state_q <= S_OUT; valid_o <= 1'b1;
            end else if (action_i == ACT_DIV && bn_w == '0) begin
              status_o <= ST_DIV_ZERO;
              r_neg_o <= 1'b0; r_num_o <= '0; r_den_o <= '0;
              state_q <= S_OUT; valid_o <= 1'b1;
            end else begin
              // first product: a_num times (b_num for multiply, else b_den)
              mc_q  <= (action_i == ACT_MUL) ? bn_w : bd_w;
              md_q  <= WW'(an_w);
              acc_q <= '0;
              cnt_q <= '0;
              mph_q <= MP_T1;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mc_q[0]) acc_q <= acc_q + md_q;
          mc_q  <= mc_q >> 1;
          md_q  <= md_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(MAG_BITS - 1)) begin
            cnt_q <= '0;
            acc_q <= '0;
            case (mph_q)
              MP_T1: begin
                t1_q  <= mc_q[0] ? acc_q + md_q : acc_q;
                mph_q <= MP_T2;
                // second product: for divide the denominator a_den*b_num
                if (act_q == ACT_DIV) begin
                  mc_q <= bn_q; md_q <= WW'(ad_q);
                end else if (act_q == ACT_MUL) begin
                  mc_q <= bd_q; md_q <= WW'(ad_q);
                end else begin
                  mc_q <= bn_q; md_q <= WW'(ad_q);
                end
              end
              MP_T2: begin
                t2_q  <= mc_q[0] ? acc_q + md_q : acc_q;
                if (act_q == ACT_MUL || act_q == ACT_DIV) begin
                  state_q <= S_ADDSUB;
                end else begin
                  mph_q <= MP_DEN;
                  mc_q <= bd_q; md_q <= WW'(ad_q);
                end
              end
              default: begin
                d_q <= mc_q[0] ? acc_q + md_q : acc_q;
                state_q <= S_ADDSUB;
              end
            endcase
          end
        end
        S_ADDSUB: begin
          if (act_q == ACT_MUL || act_q == ACT_DIV) begin
            n_q <= t1_q; d_q <= t2_q; neg_q <= sa_q ^ sb_q;
          end else if (sa_q == eb_w) begin
            n_q <= t1_q + t2_q; neg_q <= sa_q;
          end else if (t1_q >= t2_q) begin
            n_q <= t1_q - t2_q; neg_q <= sa_q;
          end else begin
            n_q <= t2_q - t1_q; neg_q <= eb_w;
          end
          state_q <= S_GCD_CHK;
          dm_q <= DV_GCD;
          x_q <= (act_q == ACT_MUL || act_q == ACT_DIV) ? t1_q :
                 (sa_q == eb_w) ? t1_q + t2_q :
                 (t1_q >= t2_q) ? t1_q - t2_q : t2_q - t1_q;
          y_q <= (act_q == ACT_MUL || act_q == ACT_DIV) ? t2_q : d_q;
        end
        S_GCD_CHK: begin
          // euclid: x mod y until y is zero; denominator is never zero so gcd > 0
          if (y_q == '0) begin
            dm_q <= DV_N;
            quo_q <= n_q; rem_q <= '0; dvs_q <= x_q; cnt_q <= '0;
            state_q <= S_DIVIDE;
          end else begin
            quo_q <= x_q; rem_q <= '0; dvs_q <= y_q; cnt_q <= '0;
            state_q <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          // restoring division, one quotient bit per cycle
          if (!sub_w[WW]) begin
            rem_q <= sub_w[WW-1:0];
            quo_q <= {quo_q[WW-2:0], 1'b1};
          end else begin
            rem_q <= rsh_w;
            quo_q <= {quo_q[WW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(WW - 1)) state_q <= (dm_q == DV_GCD) ? S_RED_N :
                                          (dm_q == DV_N) ? S_RED_D : S_FINAL;
        end
        S_RED_N: begin
          // gcd step done (the numerator quotient is taken in S_RED_D)
          if (dm_q == DV_GCD) begin
            x_q <= y_q; y_q <= rem_q; state_q <= S_GCD_CHK;
          end else begin
            n_q <= quo_q;
            dm_q <= DV_D;
            quo_q <= d_q; rem_q <= '0; cnt_q <= '0;
            state_q <= S_DIVIDE;
          end
        end
        S_RED_D: begin
          n_q <= quo_q;
          dm_q <= DV_D;
          quo_q <= d_q; rem_q <= '0; cnt_q <= '0;
          state_q <= S_DIVIDE;
        end
        S_FINAL: begin
          valid_o <= 1'b1;
          state_q <= S_OUT;
          if (n_q == '0) begin
            status_o <= ST_OK; r_neg_o <= 1'b0; r_num_o <= '0; r_den_o <= 31'd1;
          end else if ((n_q >> MAG_BITS) != '0 || (quo_q >> MAG_BITS) != '0) begin
            status_o <= ST_OVERFLOW; r_neg_o <= 1'b0; r_num_o <= '0; r_den_o <= '0;
          end else begin
            status_o <= ST_OK; r_neg_o <= neg_q;
            r_num_o <= 31'(n_q[MAG_BITS-1:0]);
            r_den_o <= 31'(quo_q[MAG_BITS-1:0]);
          end
        end
        S_OUT: begin
          if (!stall_i) begin
            valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/rau_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module rau_checker
  import rau_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        stall_o,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [30:0] r_num_o,
  input wire logic [30:0] r_den_o,
  input wire logic [1:0]  status_o
);
  logic in_xfer_w, out_wait_w, out_err_w, out_ok_w, out_clr_w;
  assign in_xfer_w  = valid_i && !stall_o;
  assign out_wait_w = valid_o && stall_i;
  assign out_err_w  = valid_o && (status_o != ST_OK);
  assign out_ok_w   = valid_o && (status_o == ST_OK);
  assign out_clr_w  = (r_num_o == '0) && (r_den_o == '0);

  `RAU_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_xfer_w, stall_o, "not busy after transfer")
  `RAU_ASSERT(a_busy_while_out, clk_i, rst_ni, !valid_o || stall_o, "result shown while idle")
  `RAU_ASSERT(a_err_zero, clk_i, rst_ni, !out_err_w || out_clr_w, "error result not cleared")
  `RAU_ASSERT(a_ok_den, clk_i, rst_ni, !out_ok_w || r_den_o != '0, "zero den on ok result")
  `RAU_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_wait_w, valid_o && $stable(r_num_o), "result changed")
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
  .valid_o(valid_o), .stall_i(stall_i), .r_num_o(r_num_o), .r_den_o(r_den_o),
  .status_o(status_o)
);
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import rau_pkg::*;

  typedef struct packed {
    action_e     action;
    logic        a_neg;
    logic [30:0] a_num;
    logic [30:0] a_den;
    logic        b_neg;
    logic [30:0] b_num;
    logic [30:0] b_den;
  } operands_t;

  typedef struct packed {
    logic        r_neg;
    logic [30:0] r_num;
    logic [30:0] r_den;
    status_e     status;
  } quotient_t;

  // one row of the directed table; the answer is typed in only when obvious
  typedef struct packed {
    operands_t ops;
    logic      known;
    quotient_t ans;
  } dir_row_t;

  localparam logic [30:0] MAG_MAX     = 31'h7FFF_FFFF;
  localparam int          RANDOM_OPS  = 1550;
  localparam int          SQUEEZE_LEN = 500;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [1:0]  action_i;
  logic        a_neg_i;
  logic [30:0] a_num_i;
  logic [30:0] a_den_i;
  logic        b_neg_i;
  logic [30:0] b_num_i;
  logic [30:0] b_den_i;
  logic        valid_o;
  logic        stall_i;
  logic        r_neg_o;
  logic [30:0] r_num_o;
  logic [30:0] r_den_o;
  logic [1:0]  status_o;

  quotient_t pending_q[$];
  dir_row_t  dir_tab[$];
  int        mismatches = 0;
  bit        squeeze_req = 1'b0;

  rational_arithmetic_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .stall_o  (stall_o),
    .action_i (action_i),
    .a_neg_i  (a_neg_i),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_neg_i  (b_neg_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .r_neg_o  (r_neg_o),
    .r_num_o  (r_num_o),
    .r_den_o  (r_den_o),
    .status_o (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // exact rational arithmetic over 64 bits, then reduction by the gcd
  function automatic quotient_t reduce_rational(input operands_t op);
    logic [63:0] an, ad, bn, bd, n, d, t1, t2, x, y, t;
    logic        neg, eff_b;
    quotient_t   q;
    an = {33'd0, op.a_num};
    ad = {33'd0, op.a_den};
    bn = {33'd0, op.b_num};
    bd = {33'd0, op.b_den};
    n = 64'd0;
    d = 64'd1;
    neg = 1'b0;
    q = '0;
    q.status = ST_OK;
    if (ad == 0 || bd == 0) begin
      q.status = ST_ZERO_DEN;
    end else if (op.action == ACT_DIV && bn == 0) begin
      q.status = ST_DIV_ZERO;
    end else if (op.action == ACT_ADD || op.action == ACT_SUB) begin
      t1 = an * bd;
      t2 = bn * ad;
      eff_b = (op.action == ACT_SUB) ? ~op.b_neg : op.b_neg;
      if (op.a_neg == eff_b) begin
        n = t1 + t2;
        neg = op.a_neg;
      end else if (t1 >= t2) begin
        n = t1 - t2;
        neg = op.a_neg;
      end else begin
        n = t2 - t1;
        neg = eff_b;
      end
      d = ad * bd;
    end else if (op.action == ACT_MUL) begin
      n = an * bn;
      d = ad * bd;
      neg = op.a_neg ^ op.b_neg;
    end else begin
      n = an * bd;
      d = ad * bn;
      neg = op.a_neg ^ op.b_neg;
    end
    if (q.status == ST_OK) begin
      x = n;
      y = d;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      if (x != 0) begin
        n = n / x;
        d = d / x;
      end
      // a zero result is always +0/1
      if (n == 0) begin
        neg = 1'b0;
        d = 64'd1;
      end
      if (n > {33'd0, MAG_MAX} || d > {33'd0, MAG_MAX}) q.status = ST_OVERFLOW;
    end
    if (q.status == ST_OK) begin
      q.r_neg = neg;
      q.r_num = n[30:0];
      q.r_den = d[30:0];
    end
    return q;
  endfunction

  function automatic dir_row_t mk_row(input action_e act, input logic an_s,
                                      input logic [30:0] an, input logic [30:0] ad,
                                      input logic bn_s, input logic [30:0] bn,
                                      input logic [30:0] bd, input logic known,
                                      input logic rn_s, input logic [30:0] rn,
                                      input logic [30:0] rd, input status_e st);
    dir_row_t r;
    r.ops = '{act, an_s, an, ad, bn_s, bn, bd};
    r.known = known;
    r.ans = '{rn_s, rn, rd, st};
    return r;
  endfunction

  // operand magnitudes: mostly small so results fit, some wide, some extremes
  function automatic logic [30:0] rand_mag(input bit allow_zero);
    logic [30:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 31'($urandom_range(0, 30));
      4, 5:       v = 31'($urandom_range(0, 65535));
      6, 7:       v = 31'($urandom);
      8:          v = MAG_MAX - 31'($urandom_range(0, 3));
      default:    v = 31'($urandom_range(0, 1));
    endcase
    if (!allow_zero && v == 0) v = 31'd1;
    return v;
  endfunction

  function automatic operands_t rand_ops();
    operands_t op;
    op.action = action_e'($urandom_range(0, 3));
    op.a_neg  = 1'($urandom_range(0, 1));
    op.b_neg  = 1'($urandom_range(0, 1));
    op.a_num  = rand_mag(1'b1);
    op.b_num  = rand_mag($urandom_range(0, 19) == 0);
    // a zero denominator now and then, otherwise well-formed operands
    op.a_den  = rand_mag($urandom_range(0, 29) == 0);
    op.b_den  = rand_mag($urandom_range(0, 29) == 0);
    return op;
  endfunction

  // holds valid with a steady payload until the transfer, then records the answer
  task automatic offer(input operands_t op, input quotient_t ans);
    int gap;
    valid_i  <= 1'b1;
    action_i <= op.action;
    a_neg_i  <= op.a_neg;
    a_num_i  <= op.a_num;
    a_den_i  <= op.a_den;
    b_neg_i  <= op.b_neg;
    b_num_i  <= op.b_num;
    b_den_i  <= op.b_den;
    do @(posedge clk_i); while (stall_o);
    pending_q.push_back(ans);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
      5:             gap = $urandom_range(10, 60);
      default:       gap = 0;
    endcase
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender
  initial begin
    operands_t op;
    valid_i     = 1'b0;
    action_i    = '0;
    a_neg_i     = 1'b0;
    a_num_i     = '0;
    a_den_i     = '0;
    b_neg_i     = 1'b0;
    b_num_i     = '0;
    b_den_i     = '0;
    rst_ni      = 1'b0;

    // zero denominators take priority over everything
    dir_tab.push_back(mk_row(ACT_DIV, 0, 5, 0, 0, 0, 3, 1, 0, 0, 0, ST_ZERO_DEN));
    dir_tab.push_back(mk_row(ACT_ADD, 1, MAG_MAX, 7, 1, 3, 0, 1, 0, 0, 0, ST_ZERO_DEN));
    // division by a zero numerator
    dir_tab.push_back(mk_row(ACT_DIV, 1, 9, 4, 0, 0, MAG_MAX, 1, 0, 0, 0, ST_DIV_ZERO));
    // zero results come out as +0/1, then results that reduce to whole numbers
    dir_tab.push_back(mk_row(ACT_ADD, 0, 0, 5, 0, 0, 9, 1, 0, 0, 1, ST_OK));
    dir_tab.push_back(mk_row(ACT_SUB, 1, 3, 4, 1, 6, 8, 1, 0, 0, 1, ST_OK));
    dir_tab.push_back(mk_row(ACT_MUL, 1, 0, 3, 0, 7, 2, 1, 0, 0, 1, ST_OK));
    dir_tab.push_back(mk_row(ACT_ADD, 0, 1, 1, 0, 1, 1, 1, 0, 2, 1, ST_OK));
    dir_tab.push_back(mk_row(ACT_MUL, 0, MAG_MAX, 1, 1, 1, MAG_MAX, 1, 1, 1, 1, ST_OK));
    dir_tab.push_back(mk_row(ACT_DIV, 1, MAG_MAX, 1, 1, MAG_MAX, 1, 1, 0, 1, 1, ST_OK));
    // overflow of the reduced parts
    dir_tab.push_back(mk_row(ACT_MUL, 0, MAG_MAX, 1, 0, 2, 1, 1, 0, 0, 0, ST_OVERFLOW));
    dir_tab.push_back(mk_row(ACT_ADD, 0, 1, MAG_MAX, 0, 1, MAG_MAX - 1,
                             1, 0, 0, 0, ST_OVERFLOW));
    dir_tab.push_back(mk_row(ACT_DIV, 0, 1, MAG_MAX, 0, MAG_MAX, 1, 1, 0, 0, 0, ST_OVERFLOW));
    // the rest left to the predictor
    dir_tab.push_back(mk_row(ACT_SUB, 0, 1, 3, 0, 1, 2, 0, 0, 0, 0, ST_OK));
    dir_tab.push_back(mk_row(ACT_ADD, 1, 7, 12, 0, 5, 18, 0, 0, 0, 0, ST_OK));
    dir_tab.push_back(mk_row(ACT_SUB, 1, MAG_MAX, MAG_MAX, 0, MAG_MAX, MAG_MAX,
                             0, 0, 0, 0, ST_OK));
    dir_tab.push_back(mk_row(ACT_DIV, 0, 6, 35, 1, 10, 21, 0, 0, 0, 0, ST_OK));
    dir_tab.push_back(mk_row(ACT_MUL, 1, 31'h5555_5555, 31'h2AAA_AAAA, 1, 31'h2AAA_AAAA,
                             31'h5555_5555, 0, 0, 0, 0, ST_OK));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i])
      offer(dir_tab[i].ops,
            dir_tab[i].known ? dir_tab[i].ans : reduce_rational(dir_tab[i].ops));

    for (int k = 0; k < RANDOM_OPS; k++) begin
      // ask the receiver for one long hold-off while we keep offering
      if (k == 40) squeeze_req = 1'b1;
      op = rand_ops();
      offer(op, reduce_rational(op));
    end
    valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver: checks each output transfer, then chooses the next stall
  initial begin
    int hold;
    bit squeezed;
    quotient_t want;
    stall_i = 1'b1;
    hold = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && valid_o && !stall_i) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          want = pending_q.pop_front();
          if (r_neg_o !== want.r_neg || r_num_o !== want.r_num ||
              r_den_o !== want.r_den || status_o !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: want %0d %0d/%0d st %0d, got %0d %0d/%0d st %0d",
                       $realtime, want.r_neg, want.r_num, want.r_den, want.status,
                       r_neg_o, r_num_o, r_den_o, status_o);
          end
        end
      end
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        hold = SQUEEZE_LEN;
      end
      if (hold > 0) begin
        hold--;
        stall_i <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        hold = $urandom_range(10, 80);
        stall_i <= 1'b1;
      end else begin
        stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog, well beyond the slowest gcd on every item
  initial begin
    #500_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/rau_pkg.sv
design/rational_arithmetic_unit.sv
design/rau_checker.sv
bench/testbench.sv
